// File: sv/tlb_fill_age_replacement_top_assert.svh
// Assertion macros for the TLB fill engine.
`ifndef TLB_FILL_AGE_REPLACEMENT_TOP_ASSERT_SVH
`define TLB_FILL_AGE_REPLACEMENT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define TFAR_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Consequence that must hold in the cycle after the antecedent.
`define TFAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TFAR_ASSERT_NOW(lbl, cond, msg)
`define TFAR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/tfar_pkg.sv
// Shared types and constants of the TLB fill engine.
`default_nettype none
package tfar_pkg;

  // Fixed field widths.
  localparam int IN_W       = 8;
  localparam int OUT_SLOT_W = 4;
  localparam int AGE_W      = 5;

  // Age limits.
  localparam logic [AGE_W-1:0] AGE_MAX = '1;
  localparam logic [AGE_W-1:0] AGE_ONE = AGE_W'(1);

  // Depth of the queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);

  // One fill request as it travels through the queue.
  typedef struct packed {
    logic [IN_W-1:0] page;
    logic [IN_W-1:0] frame;
  } fill_req_t;

  // One fill result.
  typedef struct packed {
    logic [OUT_SLOT_W-1:0] slot;
    logic                  evict;
    logic [IN_W-1:0]       page;
    logic [IN_W-1:0]       frame;
  } fill_res_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Status of the back end.
  typedef struct packed {
    logic table_full;
    logic writing;
  } back_stat_t;

endpackage
`default_nettype wire

// File: sv/tfar_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module tfar_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port at the same address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// File: sv/tfar_queue.sv
// Short request queue that decouples the front end from the back end.
`default_nettype none
module tfar_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire tfar_pkg::fill_req_t push_data,
  input  wire logic                pop,
  output tfar_pkg::fill_req_t      head,
  output tfar_pkg::q_stat_t        stat
);
  import tfar_pkg::*;

  fill_req_t      mem_r [QDEPTH];
  logic [QPW-1:0] wr_r;
  logic [QPW-1:0] rd_r;
  logic [QPW:0]   cnt_r;
  logic [QPW:0]   cnt_nxt;

  // Occupancy after this cycle's push and pop.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QPW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QPW+1)'(1);
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + QPW'(1);
      end
      if (pop) begin
        rd_r <= rd_r + QPW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  assign head       = mem_r[rd_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == (QPW+1)'(QDEPTH));

endmodule
`default_nettype wire

// File: sv/tfar_front.sv
// Front end: takes fill transactions and reduces page and frame into range.
`default_nettype none
module tfar_front #(
  parameter int NUMBER_RANGE = 256
) (
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [tfar_pkg::IN_W-1:0] in_page_number,
  input  wire logic [tfar_pkg::IN_W-1:0] in_frame_number,
  input  wire tfar_pkg::q_stat_t         qs,
  output logic                           push,
  output tfar_pkg::fill_req_t            req
);
  import tfar_pkg::*;

  // Wide enough for the range shifted left by three.
  localparam int RW = $clog2(NUMBER_RANGE) + 5;

  // Modulo by restoring subtraction; exact for 8-bit input if NUMBER_RANGE >= 16.
  function automatic logic [IN_W-1:0] reduce(input logic [IN_W-1:0] v);
    logic [RW-1:0] acc;
    logic [RW-1:0] sub;
    acc = RW'(v);
    for (int k = 3; k >= 0; k--) begin
      sub = RW'(NUMBER_RANGE) << k;
      if (acc >= sub) begin
        acc = acc - sub;
      end
    end
    return acc[IN_W-1:0];
  endfunction

  // A transaction is taken whenever the queue has room.
  assign busy      = qs.full;
  assign push      = start && !qs.full;
  assign req.page  = reduce(in_page_number);
  assign req.frame = reduce(in_frame_number);

endmodule
`default_nettype wire

// File: sv/tfar_back.sv
// Back end: picks the slot, reads the victim, writes the entry and ages the table.
`default_nettype none
module tfar_back #(
  parameter int SLOTS        = 16,
  parameter int NUMBER_RANGE = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tfar_pkg::q_stat_t   qs,
  input  wire tfar_pkg::fill_req_t head,
  output logic                     pop,
  output logic                     res_strobe,
  output tfar_pkg::fill_res_t      res,
  output tfar_pkg::back_stat_t     bs
);
  import tfar_pkg::*;

  localparam int SW      = $clog2(SLOTS);
  localparam int P2      = 1 << SW;
  localparam int STORE_W = (NUMBER_RANGE >= 256) ? IN_W : $clog2(NUMBER_RANGE);

  typedef enum logic {
    S_IDLE,
    S_WRITE
  } state_t;

  state_t             state_r;
  logic [SLOTS-1:0]   valid_r;
  logic [AGE_W-1:0]   age_r   [SLOTS];
  logic [AGE_W-1:0]   age_nxt [SLOTS];
  logic [SW-1:0]      cnt_r;
  logic [SW-1:0]      slot_r;
  logic               evict_r;
  logic [STORE_W-1:0] page_r;
  logic [STORE_W-1:0] frame_r;
  logic               strobe_r;
  fill_res_t          res_r;

  logic                 full;
  logic [SW-1:0]        pick;
  logic [SW-1:0]        ram_addr;
  logic                 ram_we;
  logic [2*STORE_W-1:0] ram_rdata;
  logic [SW+OUT_SLOT_W-1:0] slot_ext;

  logic [AGE_W-1:0] t_age [SW+1][P2];
  logic [SW-1:0]    t_idx [SW+1][P2];

  assign full = valid_r[SLOTS-1];

  // Oldest-entry tree; the left side wins a tie, so the lowest index is chosen.
  always_comb begin
    for (int l = 0; l <= SW; l++) begin
      for (int j = 0; j < P2; j++) begin
        t_age[l][j] = '0;
        t_idx[l][j] = '0;
      end
    end
    for (int j = 0; j < SLOTS; j++) begin
      t_age[0][j] = age_r[j];
      t_idx[0][j] = SW'(j);
    end
    for (int l = 0; l < SW; l++) begin
      for (int j = 0; j < (P2 >> (l + 1)); j++) begin
        if (t_age[l][2*j+1] > t_age[l][2*j]) begin
          t_age[l+1][j] = t_age[l][2*j+1];
          t_idx[l+1][j] = t_idx[l][2*j+1];
        end else begin
          t_age[l+1][j] = t_age[l][2*j];
          t_idx[l+1][j] = t_idx[l][2*j];
        end
      end
    end
  end

  // Slots fill in order, so the fill count is the lowest free slot.
  assign pick = full ? t_idx[SW][0] : cnt_r;

  // Saturating ageing of valid entries; the written entry restarts at one.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      if (SW'(i) == slot_r) begin
        age_nxt[i] = AGE_ONE;
      end else if (valid_r[i] && (age_r[i] != AGE_MAX)) begin
        age_nxt[i] = age_r[i] + AGE_W'(1);
      end else begin
        age_nxt[i] = age_r[i];
      end
    end
  end

  // The victim is read in the pick cycle and overwritten in the write cycle.
  assign ram_we   = (state_r == S_WRITE);
  assign ram_addr = (state_r == S_WRITE) ? slot_r : pick;
  assign pop      = (state_r == S_IDLE) && !qs.empty;
  assign slot_ext = {{OUT_SLOT_W{1'b0}}, slot_r};

  tfar_ram #(
    .WIDTH (2*STORE_W),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({page_r, frame_r}),
    .rdata (ram_rdata)
  );

  // Sequencer, table state and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!qs.empty) begin
            slot_r  <= pick;
            evict_r <= full;
            page_r  <= head.page[STORE_W-1:0];
            frame_r <= head.frame[STORE_W-1:0];
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          valid_r[slot_r] <= 1'b1;
          age_r           <= age_nxt;
          if (!evict_r) begin
            cnt_r <= cnt_r + SW'(1);
          end
          strobe_r    <= 1'b1;
          res_r.slot  <= slot_ext[OUT_SLOT_W-1:0];
          res_r.evict <= evict_r;
          res_r.page  <= evict_r ? IN_W'(ram_rdata[2*STORE_W-1:STORE_W]) : '0;
          res_r.frame <= evict_r ? IN_W'(ram_rdata[STORE_W-1:0]) : '0;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign res_strobe    = strobe_r;
  assign res           = res_r;
  assign bs.table_full = full;
  assign bs.writing    = (state_r == S_WRITE);

endmodule
`default_nettype wire

// File: sv/tlb_fill_age_replacement_top.sv
// Top level of the TLB fill engine with age-based replacement.
`default_nettype none
`include "tlb_fill_age_replacement_top_assert.svh"
// A fill transaction is taken at a clock edge where start is high and busy is low;
// busy rises only when the two-entry request queue is full. Each transaction yields
// exactly one result, shown for one cycle with out_strobe high; the receiver cannot
// stall, so results must be taken as they appear. For each fill the back end first
// chooses the slot through the age compare tree and reads the victim from the
// entry RAM, then writes the new entry and ages the table. The next pick needs the
// ages left by the previous write, so a fill leaves the queue only once the last is
// written, and each result passes the pick and write states. No clearing pass is
// needed after reset: entries are only read once written.
module tlb_fill_age_replacement_top #(
  parameter int SLOTS        = 16,
  parameter int NUMBER_RANGE = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [tfar_pkg::IN_W-1:0]       in_page_number,
  input  wire logic [tfar_pkg::IN_W-1:0]       in_frame_number,
  output logic                                 out_strobe,
  output logic      [tfar_pkg::OUT_SLOT_W-1:0] out_slot_written,
  output logic                                 out_did_evict,
  output logic      [tfar_pkg::IN_W-1:0]       out_evicted_page,
  output logic      [tfar_pkg::IN_W-1:0]       out_evicted_frame
);
  import tfar_pkg::*;

  q_stat_t    qs;
  fill_req_t  req;
  fill_req_t  head;
  logic       push;
  logic       pop;
  fill_res_t  res;
  back_stat_t bs;

  // Front end.
  tfar_front #(
    .NUMBER_RANGE (NUMBER_RANGE)
  ) u_front (
    .start           (start),
    .busy            (busy),
    .in_page_number  (in_page_number),
    .in_frame_number (in_frame_number),
    .qs              (qs),
    .push            (push),
    .req             (req)
  );

  // Request queue.
  tfar_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (req),
    .pop       (pop),
    .head      (head),
    .stat      (qs)
  );

  // Back end.
  tfar_back #(
    .SLOTS        (SLOTS),
    .NUMBER_RANGE (NUMBER_RANGE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qs         (qs),
    .head       (head),
    .pop        (pop),
    .res_strobe (out_strobe),
    .res        (res),
    .bs         (bs)
  );

  assign out_slot_written  = res.slot;
  assign out_did_evict     = res.evict;
  assign out_evicted_page  = res.page;
  assign out_evicted_frame = res.frame;

  // Checks on the sequencing of the back end.
  `TFAR_ASSERT_NEXT(a_strobe_spacing, out_strobe, !out_strobe, "results closer than two cycles")
  `TFAR_ASSERT_NOW(a_strobe_after_write, !out_strobe || $past(bs.writing), "result without write")
  `TFAR_ASSERT_NOW(a_evict_when_full, !(out_strobe && out_did_evict) || bs.table_full, "early eviction")
  `TFAR_ASSERT_NEXT(a_full_sticks, bs.table_full, bs.table_full, "table lost an entry")

endmodule
`default_nettype wire
